[rtl/gfrma_pkg.sv]
// Package for the GF(2^64) region multiply-add core.
// Request/response payload types, config register indexes and the
// carry-less multiply and reduction helpers. No dependencies.
package gfrma_pkg;

    localparam int NUM_FIELDS    = 4;   // element lanes carried by one request
    localparam int NUM_COEF_REGS = 4;   // coefficient registers
    localparam int ELEM_W        = 64;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int PART_W        = 63;  // 32x32 carry-less product
    localparam int SUM_W         = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_COUNT = 3'd4;
    localparam logic [CNT_W-1:0]     COEF_COUNT_RST = 3'd1;

    typedef logic [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic             op;
        logic [CNT_W-1:0] lane_count;
        t_elem            elem_0;
        t_elem            elem_1;
        t_elem            elem_2;
        t_elem            elem_3;
        t_elem            prior_0;
        t_elem            prior_1;
        t_elem            prior_2;
        t_elem            prior_3;
    } t_req;

    typedef struct packed {
        t_elem            result_0;
        t_elem            result_1;
        t_elem            result_2;
        t_elem            result_3;
        logic [CNT_W-1:0] result_count;
    } t_rsp;

    // Sideband that travels down the pipe next to the lane products
    typedef struct packed {
        logic                             valid;
        logic                             op;
        logic [CNT_W-1:0]                 lane_count;
        logic [NUM_FIELDS-1:0]            lane_en;
        logic [NUM_FIELDS-1:0][ELEM_W-1:0] prior;
    } t_side;

    function automatic logic [PART_W-1:0] clmul32(input logic [31:0] a, input logic [31:0] b);
        logic [PART_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 32; k++) begin
            if (b[k]) begin
                acc = acc ^ ({31'b0, a} << k);
            end
        end
        return acc;
    endfunction

    // times x^4 + x^3 + x + 1, low 64 bits kept
    function automatic t_elem times_poly(input t_elem v);
        return (v << 4) ^ (v << 3) ^ (v << 1) ^ v;
    endfunction

    function automatic t_elem reduce128(input logic [SUM_W-1:0] v);
        t_elem      hi;
        logic [3:0] over;
        hi   = v[SUM_W-1:ELEM_W];
        // bits pushed past x^63 by the first fold
        over = {hi[63], hi[62] ^ hi[63], hi[61] ^ hi[62], hi[60] ^ hi[61] ^ hi[63]};
        return v[ELEM_W-1:0] ^ times_poly(hi) ^ times_poly({60'b0, over});
    endfunction

endpackage

[rtl/gf64_region_multiply_add_core.sv]
// GF(2^64) region multiply-add core, top level.
// An accepted request passes the partial-product, lane-sum and response registers before its o_done strobe.
// Throughput: one request per cycle; multiply, combine and reduce each own a stage.
// o_busy is high only while in reset; the result strobe cannot be stalled.
// Reset clears coefficients to zero, coef_count to one, and empties the pipe.
// Depends on gfrma_pkg, gfrma_lane, gfrma_merge.
module gf64_region_multiply_add_core #(
    parameter int LANES      = 4,
    parameter int MAX_COEFFS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  gfrma_pkg::t_req                    i_req,
    output logic                               o_done,
    output gfrma_pkg::t_rsp                    o_rsp,
    input  logic                               i_cfg_we,
    input  logic [gfrma_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gfrma_pkg::ELEM_W-1:0]       i_cfg_wdata
);
    import gfrma_pkg::*;

    localparam int NUM_HW = (LANES < NUM_FIELDS) ? LANES : NUM_FIELDS;
    localparam int NUM_CF = (MAX_COEFFS < NUM_COEF_REGS) ? MAX_COEFFS : NUM_COEF_REGS;

    t_elem [NUM_CF-1:0]              r_coef;
    logic  [CNT_W-1:0]               r_coef_count;
    logic  [NUM_CF-1:0]              coef_en;
    t_elem [NUM_FIELDS-1:0]          elem_arr;
    logic  [NUM_FIELDS-1:0][SUM_W-1:0] lane_sum;
    t_side                           n_side;
    t_side                           r_side1;
    t_side                           r_side2;
    logic                            req_acc;

    assign o_busy  = !i_rst_n;
    assign req_acc = i_start && !o_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef       <= '0;
            r_coef_count <= COEF_COUNT_RST;
        end else if (i_cfg_we) begin
            for (int c = 0; c < NUM_CF; c++) begin
                if (i_cfg_idx == CFG_COEF_BASE + CFG_IDX_W'(c)) begin
                    r_coef[c] <= i_cfg_wdata;
                end
            end
            if (i_cfg_idx == CFG_COEF_COUNT) begin
                r_coef_count <= i_cfg_wdata[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CF; c++) begin
            coef_en[c] = CNT_W'(c) < r_coef_count;
        end
    end

    assign elem_arr = {i_req.elem_3, i_req.elem_2, i_req.elem_1, i_req.elem_0};

    always_comb begin
        n_side.valid      = req_acc;
        n_side.op         = i_req.op;
        n_side.lane_count = i_req.lane_count;
        n_side.prior      = {i_req.prior_3, i_req.prior_2, i_req.prior_1, i_req.prior_0};
        for (int k = 0; k < NUM_FIELDS; k++) begin
            n_side.lane_en[k] = (k < NUM_HW) && (CNT_W'(k) < i_req.lane_count);
        end
    end

    // sideband pipe, aligned with the two lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
        end else begin
            r_side1.valid <= n_side.valid;
            r_side2.valid <= r_side1.valid;
        end
        r_side1.op         <= n_side.op;
        r_side1.lane_count <= n_side.lane_count;
        r_side1.lane_en    <= n_side.lane_en;
        r_side1.prior      <= n_side.prior;
        r_side2.op         <= r_side1.op;
        r_side2.lane_count <= r_side1.lane_count;
        r_side2.lane_en    <= r_side1.lane_en;
        r_side2.prior      <= r_side1.prior;
    end

    for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
        if (k < NUM_HW) begin : g_hw
            gfrma_lane #(
                .NCOEF (NUM_CF)
            ) u_lane (
                .i_clk     (i_clk),
                .i_elem    (elem_arr[k]),
                .i_coef    (r_coef),
                .i_coef_en (coef_en),
                .o_sum     (lane_sum[k])
            );
        end else begin : g_none
            assign lane_sum[k] = '0;
        end
    end

    gfrma_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side2),
        .i_sum   (lane_sum),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(req_acc, 3))
        else $error("response strobe without a request three cycles earlier");

    a_request_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> ##3 o_done)
        else $error("accepted request produced no response");

    a_invalid_lanes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_rsp.result_count > 3'd1 || o_rsp.result_1 == '0) &&
                    (o_rsp.result_count > 3'd2 || o_rsp.result_2 == '0) &&
                    (o_rsp.result_count > 3'd3 || o_rsp.result_3 == '0)))
        else $error("result in a lane beyond the valid count is not zero");

endmodule

[rtl/gfrma_lane.sv]
// One element lane: carry-less multiply of the element by each coefficient,
// split into 32x32 partial products (stage 1), then XOR-combined (stage 2).
// Depends on gfrma_pkg.
module gfrma_lane #(
    parameter int NCOEF = 4
) (
    input  logic                            i_clk,
    input  gfrma_pkg::t_elem                i_elem,
    input  gfrma_pkg::t_elem [NCOEF-1:0]    i_coef,
    input  logic [NCOEF-1:0]                i_coef_en,
    output logic [gfrma_pkg::SUM_W-1:0]     o_sum
);
    import gfrma_pkg::*;

    t_elem [NCOEF-1:0]                  coef_m;
    logic  [NCOEF-1:0][3:0][PART_W-1:0] n_part;
    logic  [NCOEF-1:0][3:0][PART_W-1:0] r_part;
    logic  [SUM_W-1:0]                  n_sum;
    logic  [SUM_W-1:0]                  r_sum;

    always_comb begin
        for (int c = 0; c < NCOEF; c++) begin
            coef_m[c]    = i_coef_en[c] ? i_coef[c] : '0;
            n_part[c][0] = clmul32(i_elem[31:0],  coef_m[c][31:0]);
            n_part[c][1] = clmul32(i_elem[31:0],  coef_m[c][63:32]);
            n_part[c][2] = clmul32(i_elem[63:32], coef_m[c][31:0]);
            n_part[c][3] = clmul32(i_elem[63:32], coef_m[c][63:32]);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < NCOEF; c++) begin
            n_sum = n_sum ^ {65'b0, r_part[c][0]}
                          ^ ({65'b0, r_part[c][1]} << 32)
                          ^ ({65'b0, r_part[c][2]} << 32)
                          ^ ({65'b0, r_part[c][3]} << 64);
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_sum  <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

[rtl/gfrma_merge.sv]
// Merge stage: reduces each lane's 128-bit sum, applies multiply-add,
// only when op is set, zeroes invalid lanes and registers the response. Depends on gfrma_pkg.
module gfrma_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  gfrma_pkg::t_side                              i_side,
    input  logic [gfrma_pkg::NUM_FIELDS-1:0][gfrma_pkg::SUM_W-1:0] i_sum,
    output logic                                          o_done,
    output gfrma_pkg::t_rsp                               o_rsp
);
    import gfrma_pkg::*;

    t_elem [NUM_FIELDS-1:0] res;
    t_rsp                   n_rsp;
    t_rsp                   r_rsp;
    logic                   r_done;

    always_comb begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
            res[k] = reduce128(i_sum[k]) ^ (i_side.op ? i_side.prior[k] : '0);
            if (!i_side.lane_en[k]) begin
                res[k] = '0;
            end
        end
        n_rsp.result_0     = res[0];
        n_rsp.result_1     = res[1];
        n_rsp.result_2     = res[2];
        n_rsp.result_3     = res[3];
        n_rsp.result_count = i_side.lane_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_side.valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
